>>> hw/rtl/pbc_pkg.sv
package pbc_pkg;

    localparam int DATA_W   = 64;
    localparam int COUNT_W  = 11;
    localparam int PREFIX_W = 13;
    localparam int VAR_W    = 12;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // item kinds
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_TERM  = 2'd1;
    localparam logic [1:0] KIND_CONST = 2'd2;
    localparam logic [1:0] KIND_CLOSE = 2'd3;

    // constraint sense
    localparam logic [1:0] SENSE_LE = 2'd0;
    localparam logic [1:0] SENSE_EQ = 2'd1;

    // register index, taken from paddr[2]
    localparam logic REG_PREFIX = 1'b0;
    localparam logic REG_TOTAL  = 1'b1;

    localparam logic [PREFIX_W-1:0] PREFIX_RESET = 13'd4096;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

    typedef struct packed {
        logic [1:0]               kind;
        logic                     beyond_prefix;
        logic                     in_store;
        logic                     last_var;
        logic signed [DATA_W-1:0] coefficient;
        logic signed [DATA_W-1:0] bound;
        logic [1:0]               sense;
        logic                     final_constraint;
    } t_stage;

    typedef struct packed {
        logic [PREFIX_W-1:0] assigned_prefix;
        logic [PREFIX_W-1:0] variable_total;
    } t_cfg;

    typedef struct packed {
        logic                     satisfied;
        logic                     all_satisfied;
        logic [COUNT_W-1:0]       satisfied_count;
        logic signed [DATA_W-1:0] term_sum;
    } t_result;

endpackage

>>> hw/rtl/pbc_if.sv
interface pbc_item_if;
    import pbc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               kind;
    logic [VAR_W-1:0]         var_index;
    logic                     bit_value;
    logic signed [DATA_W-1:0] coefficient;
    logic                     last_var;
    logic signed [DATA_W-1:0] bound;
    logic [1:0]               sense;
    logic                     final_constraint;

    modport source (
        output valid, kind, var_index, bit_value, coefficient, last_var, bound, sense,
               final_constraint,
        input  ready
    );
    modport sink (
        input  valid, kind, var_index, bit_value, coefficient, last_var, bound, sense,
               final_constraint,
        output ready
    );
endinterface

interface pbc_result_if;
    import pbc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     satisfied;
    logic                     all_satisfied;
    logic [COUNT_W-1:0]       satisfied_count;
    logic signed [DATA_W-1:0] term_sum;

    modport source (
        output valid, satisfied, all_satisfied, satisfied_count, term_sum,
        input  ready
    );
    modport sink (
        input  valid, satisfied, all_satisfied, satisfied_count, term_sum,
        output ready
    );
endinterface

>>> hw/rtl/pbc_ram.sv
module pbc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/pbc_eval.sv
module pbc_eval (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s1_vld,
    input  pbc_pkg::t_stage i_s1,
    input  logic            i_rd_bit,
    input  pbc_pkg::t_cfg   i_cfg,
    output logic            o_s1_fire,
    pbc_result_if.source    o_result
);
    import pbc_pkg::*;

    logic               r_prod, n_prod;
    logic               r_oor, n_oor;
    logic [DATA_W-1:0]  r_sum, n_sum;
    logic               r_all, n_all;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic               r_out_vld, n_out_vld;
    t_result            r_out, n_out;

    logic               is_close;
    logic               out_free;
    logic               s1_fire;
    logic               var_bit;
    logic               term_prod;
    logic               term_oor;
    logic               fin_prod;
    logic               fin_oor;
    logic               coef_neg;
    logic               add_en;
    logic [DATA_W-1:0]  sum_add;
    logic               le_fail;
    logic               eq_fail;
    logic               sat;
    logic [COUNT_W-1:0] cnt_sat;
    logic               all_new;

    always_comb begin
        is_close  = (i_s1.kind == KIND_CLOSE);
        out_free  = !r_out_vld || o_result.ready;
        s1_fire   = i_s1_vld && (!is_close || out_free);

        // out-of-range variables leave the product alone
        var_bit   = i_s1.in_store & i_rd_bit;
        term_prod = r_prod & (i_s1.beyond_prefix | var_bit);
        term_oor  = r_oor | i_s1.beyond_prefix;
        fin_prod  = (i_s1.kind == KIND_TERM) ? term_prod : r_prod;
        fin_oor   = (i_s1.kind == KIND_TERM) ? term_oor : r_oor;

        // negative coefficient: subtract it (add magnitude) when product is 0
        coef_neg  = i_s1.coefficient[DATA_W-1];
        add_en    = !fin_oor && (coef_neg ? !fin_prod : fin_prod);
        sum_add   = r_sum + (coef_neg ? ~i_s1.coefficient : i_s1.coefficient)
                    + DATA_W'(coef_neg);

        le_fail   = (i_s1.sense == SENSE_LE) && ($signed(r_sum) > i_s1.bound);
        eq_fail   = (i_s1.sense == SENSE_EQ)
                    && (i_cfg.assigned_prefix == i_cfg.variable_total)
                    && (r_sum != i_s1.bound);
        sat       = !(le_fail || eq_fail);
        cnt_sat   = (sat && (r_cnt != COUNT_MAX)) ? r_cnt + 1'b1 : r_cnt;
        all_new   = r_all & sat;
    end

    always_comb begin
        n_prod    = r_prod;
        n_oor     = r_oor;
        n_sum     = r_sum;
        n_all     = r_all;
        n_cnt     = r_cnt;
        n_out_vld = r_out_vld && !o_result.ready;
        n_out     = r_out;
        if (s1_fire) begin
            case (i_s1.kind)
                KIND_TERM: begin
                    if (i_s1.last_var) begin
                        n_sum  = add_en ? sum_add : r_sum;
                        n_prod = 1'b1;
                        n_oor  = 1'b0;
                    end else begin
                        n_prod = term_prod;
                        n_oor  = term_oor;
                    end
                end
                KIND_CONST: begin
                    n_sum  = add_en ? sum_add : r_sum;
                    n_prod = 1'b1;
                    n_oor  = 1'b0;
                end
                KIND_CLOSE: begin
                    n_out_vld             = 1'b1;
                    n_out.satisfied       = sat;
                    n_out.all_satisfied   = all_new;
                    n_out.satisfied_count = cnt_sat;
                    n_out.term_sum        = r_sum;
                    n_sum                 = '0;
                    n_prod                = 1'b1;
                    n_oor                 = 1'b0;
                    n_all                 = i_s1.final_constraint ? 1'b1 : all_new;
                    n_cnt                 = i_s1.final_constraint ? '0 : cnt_sat;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod    <= 1'b1;
            r_oor     <= 1'b0;
            r_sum     <= '0;
            r_all     <= 1'b1;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_prod    <= n_prod;
            r_oor     <= n_oor;
            r_sum     <= n_sum;
            r_all     <= n_all;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
        r_out <= n_out;
    end

    assign o_s1_fire                = s1_fire;
    assign o_result.valid           = r_out_vld;
    assign o_result.satisfied       = r_out.satisfied;
    assign o_result.all_satisfied   = r_out.all_satisfied;
    assign o_result.satisfied_count = r_out.satisfied_count;
    assign o_result.term_sum        = r_out.term_sum;

    a_close_clears_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && is_close |=> r_prod && !r_oor && (r_sum == '0))
        else $error("term state not cleared after close");

    a_all_implies_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.all_satisfied |-> r_out.satisfied)
        else $error("all_satisfied set on a failing constraint");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s1_fire && is_close) |=> $stable(r_cnt))
        else $error("satisfied count moved without a close");
endmodule

>>> hw/rtl/pseudo_boolean_constraint_check.sv
// Checks pseudo-boolean constraints against an assignment held in a one-bit-wide
// RAM of NUM_VARS entries. One word is accepted per cycle: load words write the
// assignment, term and constant words accumulate the left hand side, and a close
// word yields one result via the stage and then the output register. Each word
// reads the RAM in its accept cycle and updates the accumulator in the next
// (a close waits there for a free output), so words stream back to back; the
// input stalls only while a close waits on an untaken result or while a clearing
// pass zeroes all NUM_VARS entries after reset; APB writes are taken throughout.
module pseudo_boolean_constraint_check #(
    parameter int NUM_VARS = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pbc_item_if.sink                     i_item,
    pbc_result_if.source                 o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pbc_pkg::APB_AW-1:0]   paddr,
    input  logic [pbc_pkg::APB_DW-1:0]   pwdata,
    output logic [pbc_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import pbc_pkg::*;

    localparam int AW = $clog2(NUM_VARS);

    t_cfg          r_cfg, n_cfg;
    logic          r_clearing, n_clearing;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic          r_s1_vld, n_s1_vld;
    t_stage        r_s1, n_s1;

    logic          accept;
    logic          cfg_we;
    logic          in_store;
    logic          load_we;
    logic          s1_fire;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [0:0]    ram_wdata;
    logic [0:0]    ram_rdata;

    assign in_store     = 32'(i_item.var_index) < NUM_VARS;
    assign i_item.ready = !r_clearing && (!r_s1_vld || s1_fire);
    assign accept       = i_item.valid && i_item.ready;
    assign load_we      = accept && (i_item.kind == KIND_LOAD) && in_store;

    // clearing pass owns the write port until it finishes
    assign ram_we    = r_clearing || load_we;
    assign ram_waddr = r_clearing ? r_clr_addr : AW'(i_item.var_index);
    assign ram_wdata = r_clearing ? 1'b0 : i_item.bit_value;

    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(NUM_VARS - 1)) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_comb begin
        n_s1_vld = r_s1_vld;
        n_s1     = r_s1;
        if (accept) begin
            n_s1_vld              = 1'b1;
            n_s1.kind             = i_item.kind;
            n_s1.beyond_prefix    = {1'b0, i_item.var_index} > r_cfg.assigned_prefix;
            n_s1.in_store         = in_store;
            n_s1.last_var         = i_item.last_var;
            n_s1.coefficient      = i_item.coefficient;
            n_s1.bound            = i_item.bound;
            n_s1.sense            = i_item.sense;
            n_s1.final_constraint = i_item.final_constraint;
        end else if (s1_fire) begin
            n_s1_vld = 1'b0;
        end
    end

    // APB
    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_we) begin
            case (paddr[2])
                REG_PREFIX: n_cfg.assigned_prefix = pwdata[PREFIX_W-1:0];
                REG_TOTAL:  n_cfg.variable_total  = pwdata[PREFIX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_PREFIX: prdata = APB_DW'(r_cfg.assigned_prefix);
            REG_TOTAL:  prdata = APB_DW'(r_cfg.variable_total);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.assigned_prefix <= PREFIX_RESET;
            r_cfg.variable_total  <= PREFIX_RESET;
            r_clearing            <= 1'b1;
            r_clr_addr            <= '0;
            r_s1_vld              <= 1'b0;
        end else begin
            r_cfg      <= n_cfg;
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
            r_s1_vld   <= n_s1_vld;
        end
        r_s1 <= n_s1;
    end

    pbc_ram #(
        .WIDTH (1),
        .DEPTH (NUM_VARS)
    ) u_bits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (AW'(i_item.var_index)),
        .o_rdata (ram_rdata)
    );

    pbc_eval u_eval (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1_vld  (r_s1_vld),
        .i_s1      (r_s1),
        .i_rd_bit  (ram_rdata[0]),
        .i_cfg     (r_cfg),
        .o_s1_fire (s1_fire),
        .o_result  (o_result)
    );

    a_clear_full_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clearing) |-> $past(r_clr_addr) == AW'(NUM_VARS - 1))
        else $error("clearing pass ended early");

    a_stage_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s1_fire |=> r_s1_vld && $stable(r_s1))
        else $error("stalled word lost");

    a_no_load_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !load_we && !r_s1_vld)
        else $error("word in flight during clearing pass");
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pbc_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_WORDS  = 30;
    localparam int SAT_CLOSES   = 2100;

    // senses beyond the checked ones: always satisfied
    localparam logic [1:0] SENSE_FREE  = 2'd2;
    localparam logic [1:0] SENSE_SPARE = 2'd3;

    localparam logic signed [DATA_W-1:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [DATA_W-1:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [1:0]               kind;
        logic [VAR_W-1:0]         var_index;
        logic                     bit_value;
        logic signed [DATA_W-1:0] coefficient;
        logic                     last_var;
        logic signed [DATA_W-1:0] bound;
        logic [1:0]               sense;
        logic                     final_constraint;
    } pb_word_t;

    // Tracks assignment, term state and set flags; predicts one verdict per close.
    class verdict_board;
        bit                       assign_mem [4096];
        logic [PREFIX_W-1:0]      prefix_reg;
        logic [PREFIX_W-1:0]      total_reg;
        bit                       prod_live;
        bit                       beyond;
        logic signed [DATA_W-1:0] lhs;
        bit                       all_held;
        logic [COUNT_W-1:0]       held_count;
        t_result                  verdict_q [$];
        int                       mismatches;
        int                       verdicts;
        int                       satisfied_seen;

        function new();
            foreach (assign_mem[i]) assign_mem[i] = 0;
            prefix_reg = PREFIX_RESET;
            total_reg  = PREFIX_RESET;
            prod_live  = 1;
            beyond     = 0;
            lhs        = '0;
            all_held   = 1;
            held_count = '0;
            mismatches = 0;
            verdicts   = 0;
            satisfied_seen = 0;
        endfunction

        function void set_reg(logic idx, logic [APB_DW-1:0] value);
            if (idx == REG_PREFIX) prefix_reg = value[PREFIX_W-1:0];
            else total_reg = value[PREFIX_W-1:0];
        endfunction

        function void end_term(logic signed [DATA_W-1:0] coef);
            if (!beyond) begin
                if (coef[DATA_W-1]) begin
                    if (!prod_live) lhs = lhs - coef;
                end else if (prod_live) begin
                    lhs = lhs + coef;
                end
            end
            prod_live = 1;
            beyond    = 0;
        endfunction

        function void take_word(pb_word_t w);
            t_result r;
            bit      ok;
            case (w.kind)
                KIND_LOAD: begin
                    assign_mem[w.var_index] = w.bit_value;
                end
                KIND_TERM: begin
                    if ({1'b0, w.var_index} > prefix_reg) beyond = 1;
                    else if (!assign_mem[w.var_index]) prod_live = 0;
                    if (w.last_var) end_term(w.coefficient);
                end
                KIND_CONST: begin
                    end_term(w.coefficient);
                end
                default: begin
                    ok = 1;
                    if (w.sense == SENSE_LE && lhs > w.bound) ok = 0;
                    if (w.sense == SENSE_EQ && prefix_reg == total_reg && lhs != w.bound)
                        ok = 0;
                    if (!ok) all_held = 0;
                    if (ok && held_count != COUNT_MAX) held_count = held_count + 1'b1;
                    r.satisfied       = ok;
                    r.all_satisfied   = all_held;
                    r.satisfied_count = held_count;
                    r.term_sum        = lhs;
                    verdict_q.push_back(r);
                    lhs       = '0;
                    prod_live = 1;
                    beyond    = 0;
                    if (w.final_constraint) begin
                        all_held   = 1;
                        held_count = '0;
                    end
                end
            endcase
        endfunction

        function void check_verdict(t_result got);
            t_result want;
            if (verdict_q.size() == 0) begin
                $error("result word with no verdict pending: term_sum %0d", got.term_sum);
                mismatches++;
                return;
            end
            want = verdict_q.pop_front();
            verdicts++;
            if (got.satisfied) satisfied_seen++;
            if (got.satisfied !== want.satisfied) begin
                $error("satisfied: expected %0d, got %0d", want.satisfied, got.satisfied);
                mismatches++;
            end
            if (got.all_satisfied !== want.all_satisfied) begin
                $error("all_satisfied: expected %0d, got %0d",
                       want.all_satisfied, got.all_satisfied);
                mismatches++;
            end
            if (got.satisfied_count !== want.satisfied_count) begin
                $error("satisfied_count: expected %0d, got %0d",
                       want.satisfied_count, got.satisfied_count);
                mismatches++;
            end
            if (got.term_sum !== want.term_sum) begin
                $error("term_sum: expected %0d, got %0d", want.term_sum, got.term_sum);
                mismatches++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    pbc_item_if   item_bus ();
    pbc_result_if result_bus ();

    pseudo_boolean_constraint_check u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    verdict_board sb;
    int           cycles;
    int           words_sent;
    int           phase_words;
    int           settings_used;
    int           burst_left;
    bit           tx_gappy;
    int           rx_mode;
    int           rx_tick;
    int           hold_requests;
    int           hold_served;
    int           hold_left;
    t_result      got_word;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d verdicts pending",
                     cycles, sb.verdict_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: long hold-off on request, otherwise a ready pattern per mode
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        rx_tick++;
        if (hold_left != 0) begin
            hold_left--;
            result_bus.ready = 1'b0;
        end else begin
            case (rx_mode)
                0: result_bus.ready = 1'b1;
                1: result_bus.ready = ($urandom_range(0, 3) != 0);
                2: result_bus.ready = ($urandom_range(0, 3) == 0);
                default: result_bus.ready = ((rx_tick % 7) >= 3);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            got_word.satisfied       = result_bus.satisfied;
            got_word.all_satisfied   = result_bus.all_satisfied;
            got_word.satisfied_count = result_bus.satisfied_count;
            got_word.term_sum        = result_bus.term_sum;
            sb.check_verdict(got_word);
        end
    end

    task automatic push_word(pb_word_t w);
        @(negedge i_clk);
        item_bus.kind             = w.kind;
        item_bus.var_index        = w.var_index;
        item_bus.bit_value        = w.bit_value;
        item_bus.coefficient      = w.coefficient;
        item_bus.last_var         = w.last_var;
        item_bus.bound            = w.bound;
        item_bus.sense            = w.sense;
        item_bus.final_constraint = w.final_constraint;
        item_bus.valid            = 1'b1;
        do @(posedge i_clk); while (!item_bus.ready);
        sb.take_word(w);
        words_sent++;
        phase_words++;
    endtask

    task automatic idle_cycles(int n);
        @(negedge i_clk);
        item_bus.valid = 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_word(pb_word_t w);
        push_word(w);
        if (tx_gappy) begin
            if (burst_left == 0) begin
                idle_cycles($urandom_range(1, 6));
                burst_left = $urandom_range(1, 20);
            end else begin
                burst_left--;
            end
        end
    endtask

    // stop sending, let every verdict arrive, then let trailing term words settle
    task automatic drain_verdicts();
        idle_cycles(1);
        while (sb.verdict_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write, then read the register back
    task automatic apb_write(logic idx, logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DW'(value[PREFIX_W-1:0])) begin
            $error("prdata: expected %0d, got %0d", value[PREFIX_W-1:0], prdata);
            sb.mismatches++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic pb_word_t mk(logic [1:0] kind, logic [VAR_W-1:0] vi, logic bv,
                                    logic signed [DATA_W-1:0] coef, logic last,
                                    logic signed [DATA_W-1:0] bnd, logic [1:0] sense,
                                    logic fin);
        pb_word_t w;
        w.kind = kind;
        w.var_index = vi;
        w.bit_value = bv;
        w.coefficient = coef;
        w.last_var = last;
        w.bound = bnd;
        w.sense = sense;
        w.final_constraint = fin;
        return w;
    endfunction

    // all fields random, so unused fields toggle too
    function automatic pb_word_t rand_word();
        return mk(2'($urandom_range(0, 3)), VAR_W'($urandom), 1'($urandom_range(0, 1)),
                  {$urandom, $urandom}, 1'($urandom_range(0, 1)), {$urandom, $urandom},
                  2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic logic [VAR_W-1:0] pick_var();
        int p;
        case ($urandom_range(0, 3))
            0: return VAR_W'($urandom_range(0, 15));
            1: begin
                p = int'(sb.prefix_reg) + $urandom_range(0, 4) - 2;
                if (p < 0) p = 0;
                if (p > 4095) p = 4095;
                return VAR_W'(p);
            end
            2: return VAR_W'($urandom);
            default: return VAR_W'($urandom_range(4090, 4095));
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_coef();
        logic signed [DATA_W-1:0] c;
        case ($urandom_range(0, 6))
            0: c = DATA_W'($urandom_range(0, 100));
            1: begin
                c = DATA_W'($urandom_range(1, 100));
                c = -c;
            end
            2: c = S64_MAX;
            3: c = S64_MIN;
            6: c = $urandom_range(0, 1) ? '1 : '0;
            default: c = {$urandom, $urandom};
        endcase
        return c;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_bound();
        logic signed [DATA_W-1:0] b;
        case ($urandom_range(0, 6))
            0: b = sb.lhs;
            1: b = sb.lhs - 1;
            2: b = sb.lhs + 1;
            3: b = {$urandom, $urandom};
            4: b = DATA_W'($signed($urandom_range(0, 400)) - 200);
            5: b = S64_MAX;
            default: b = S64_MIN;
        endcase
        return b;
    endfunction

    // one constraint: optional loads, product terms ended in varying ways, close
    task automatic gen_constraint();
        pb_word_t w;
        int       n_terms;
        int       n_vars;
        int       end_style;
        int       pick;
        n_terms = $urandom_range(0, 4);
        for (int t = 0; t < n_terms; t++) begin
            if ($urandom_range(0, 9) < 3) begin
                w = rand_word();
                w.kind = KIND_LOAD;
                w.var_index = pick_var();
                send_word(w);
            end
            n_vars    = $urandom_range(0, 3);
            end_style = $urandom_range(0, 9);
            for (int v = 0; v < n_vars; v++) begin
                w = rand_word();
                w.kind = KIND_TERM;
                w.var_index = pick_var();
                w.coefficient = pick_coef();
                w.last_var = (v == n_vars - 1) && (end_style < 6);
                send_word(w);
            end
            // style 9 leaves the term open; it carries into the next one or the close
            if (n_vars == 0 || (end_style >= 6 && end_style < 9)) begin
                w = rand_word();
                w.kind = KIND_CONST;
                w.coefficient = pick_coef();
                send_word(w);
            end
        end
        w = rand_word();
        w.kind = KIND_CLOSE;
        w.bound = pick_bound();
        pick = $urandom_range(0, 9);
        w.sense = (pick < 4) ? SENSE_LE : (pick < 8) ? SENSE_EQ :
                  (pick == 8) ? SENSE_FREE : SENSE_SPARE;
        w.final_constraint = ($urandom_range(0, 3) == 0);
        send_word(w);
    endtask

    task automatic run_phase(logic [APB_DW-1:0] pfx, logic [APB_DW-1:0] tot, int mode,
                             bit gappy, bit long_hold);
        drain_verdicts();
        apb_write(REG_PREFIX, pfx);
        apb_write(REG_TOTAL, tot);
        settings_used++;
        rx_mode     = mode;
        tx_gappy    = gappy;
        burst_left  = $urandom_range(1, 20);
        phase_words = 0;
        while (phase_words < PHASE_WORDS) begin
            if (long_hold && phase_words >= 10 && hold_requests == hold_served
                && hold_requests == 0)
                hold_requests++;
            if ($urandom_range(0, 12) == 0) begin
                repeat ($urandom_range(1, 4)) send_word(rand_word());
            end else begin
                gen_constraint();
            end
        end
    endtask

    initial begin
        int p;
        sb            = new;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        item_bus.valid            = 1'b0;
        item_bus.kind             = KIND_LOAD;
        item_bus.var_index        = '0;
        item_bus.bit_value        = 1'b0;
        item_bus.coefficient      = '0;
        item_bus.last_var         = 1'b0;
        item_bus.bound            = '0;
        item_bus.sense            = SENSE_LE;
        item_bus.final_constraint = 1'b0;
        result_bus.ready          = 1'b0;
        cycles        = 0;
        words_sent    = 0;
        settings_used = 1;
        tx_gappy      = 0;
        rx_mode       = 0;
        rx_tick       = 0;
        hold_requests = 0;
        hold_served   = 0;
        hold_left     = 0;
        burst_left    = 0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, wrap, negative coefficients, open terms, all senses
        rx_mode = 1;
        push_word(mk(KIND_LOAD, 0, 1, 0, 0, 0, SENSE_LE, 0));
        push_word(mk(KIND_LOAD, 4095, 1, 0, 0, 0, SENSE_LE, 0));
        push_word(mk(KIND_LOAD, 5, 0, 0, 0, 0, SENSE_LE, 0));
        push_word(mk(KIND_TERM, 0, 0, 0, 0, 0, SENSE_LE, 0));
        push_word(mk(KIND_TERM, 4095, 0, S64_MAX, 1, 0, SENSE_LE, 0));
        push_word(mk(KIND_CONST, 0, 0, 1, 0, 0, SENSE_LE, 0));
        push_word(mk(KIND_CLOSE, 0, 0, 0, 0, S64_MAX, SENSE_LE, 0));
        push_word(mk(KIND_TERM, 5, 0, -64'sd5, 1, 0, SENSE_LE, 0));
        push_word(mk(KIND_CONST, 0, 0, S64_MIN, 0, 0, SENSE_LE, 0));
        push_word(mk(KIND_TERM, 0, 0, 0, 0, 0, SENSE_LE, 0));
        push_word(mk(KIND_CONST, 0, 0, 7, 0, 0, SENSE_LE, 0));
        push_word(mk(KIND_CLOSE, 0, 0, 0, 0, 11, SENSE_EQ, 0));
        push_word(mk(KIND_TERM, 0, 0, 9, 0, 0, SENSE_LE, 0));
        push_word(mk(KIND_CLOSE, 0, 0, 0, 0, S64_MIN, SENSE_FREE, 0));
        push_word(mk(KIND_CONST, 0, 0, 3, 0, 0, SENSE_LE, 0));
        push_word(mk(KIND_CLOSE, 0, 0, 0, 0, S64_MIN, SENSE_SPARE, 1));
        push_word(mk(KIND_CONST, 0, 0, -64'sd1, 0, 0, SENSE_LE, 0));
        push_word(mk(KIND_CONST, 0, 0, S64_MAX, 0, 0, SENSE_LE, 0));
        push_word(mk(KIND_CLOSE, 0, 0, 0, 0, S64_MIN, SENSE_LE, 0));
        push_word(mk(KIND_CLOSE, 0, 0, 0, 0, 0, SENSE_EQ, 1));
        push_word(mk(KIND_LOAD, 4095, 0, 0, 0, 0, SENSE_LE, 0));

        // random phases over register settings, extremes first
        run_phase(0, 0, 1, 1, 0);
        run_phase(0, 4096, 3, 0, 0);
        run_phase(4096, 0, 0, 1, 1);
        run_phase(4096, 4096, 2, 1, 0);
        p = $urandom_range(0, 4096);
        run_phase(p, p, 1, 0, 0);
        run_phase($urandom_range(0, 4096), $urandom_range(0, 4096), 3, 1, 0);
        run_phase($urandom, $urandom, 1, 1, 0);
        run_phase(2047, 2047, 0, 0, 0);
        run_phase(4095, 4096, 2, 1, 0);

        // long set of always-satisfied closes drives the count into saturation
        drain_verdicts();
        rx_mode  = 0;
        tx_gappy = 0;
        repeat (SAT_CLOSES) push_word(mk(KIND_CLOSE, 0, 0, 0, 0, 0, SENSE_FREE, 0));
        push_word(mk(KIND_CLOSE, 0, 0, 0, 0, 0, SENSE_SPARE, 1));

        drain_verdicts();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d words and %0d verdicts (%0d satisfied)",
                 words_sent, sb.verdicts, sb.satisfied_seen);
        $display("over %0d register settings, with stalls, bursts and count saturation",
                 settings_used);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
